>>> hdl/radial_table_interpolator_assert.svh
// Assertion macros for the radial table interpolator.
// Used by the top level only; needs a clock named clock and a reset named reset.
`ifndef RADIAL_TABLE_INTERPOLATOR_ASSERT_SVH
`define RADIAL_TABLE_INTERPOLATOR_ASSERT_SVH

// same-cycle implication
`define RTI_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("radial_table_interpolator assertion failed");

// next-cycle implication
`define RTI_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("radial_table_interpolator assertion failed");

`endif

>>> hdl/rti_pkg.sv
// Shared types and constants of the radial table interpolator.
// No dependencies.
package rti_pkg;

   localparam logic [1:0] OP_RADIUS = 2'd0;
   localparam logic [1:0] OP_SAMPLE = 2'd1;
   localparam logic [1:0] OP_QUERY  = 2'd2;

   localparam logic signed [63:0] Q_ONE     = 64'sd1 <<< 30;
   localparam logic signed [63:0] MD_LIM    = (64'sd1 <<< 61) - 64'sd1;
   localparam logic signed [63:0] SLOPE_LIM = 64'sd1 <<< 40;

   typedef struct packed {
      logic              start;
      logic signed [63:0] a;
      logic signed [63:0] b;
      logic signed [63:0] c;
   } md_req_type;

   typedef struct packed {
      logic              done;
      logic signed [63:0] result;
   } md_rsp_type;

endpackage

>>> hdl/rti_muldiv.sv
// Shared multiply-divide unit: a*b/c exact, truncated toward zero, saturated.
// Four 32x32 partial products, then a 128-step restoring division, or a shift
// when c is Q_ONE. Uses rti_pkg.
module rti_muldiv import rti_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  md_req_type md_req,
   output md_rsp_type md_rsp
);

   typedef enum logic [1:0] {U_IDLE, U_MUL, U_DIV, U_DONE} unit_state_type;

   unit_state_type state_ff;
   logic [63:0]  mag_a_ff, mag_b_ff, div_ff, rem_ff;
   logic [127:0] acc_ff;
   logic         neg_ff, zero_ff, pow2_ff;
   logic [6:0]   cnt_ff;

   logic [63:0]  mag_a_in, mag_b_in, mag_c_in;
   logic [31:0]  part_a, part_b;
   logic [63:0]  pp;
   logic [127:0] pp_sh, acc_sum;
   logic [64:0]  rem_sh, rem_sub;
   logic         rem_ge;
   logic         over;
   logic signed [63:0] mag_q;

   always_comb begin
      mag_a_in = md_req.a[63] ? (~md_req.a + 64'd1) : md_req.a;
      mag_b_in = md_req.b[63] ? (~md_req.b + 64'd1) : md_req.b;
      mag_c_in = md_req.c[63] ? (~md_req.c + 64'd1) : md_req.c;
      part_a   = cnt_ff[0] ? mag_a_ff[63:32] : mag_a_ff[31:0];
      part_b   = cnt_ff[1] ? mag_b_ff[63:32] : mag_b_ff[31:0];
      pp       = 64'(part_a) * 64'(part_b);
      case (cnt_ff[1:0])
         2'd0:    pp_sh = {64'd0, pp};
         2'd3:    pp_sh = {pp, 64'd0};
         default: pp_sh = {32'd0, pp, 32'd0};
      endcase
      acc_sum = acc_ff + pp_sh;
      rem_sh  = {rem_ff, acc_ff[127]};
      rem_ge  = rem_sh >= {1'b0, div_ff};
      rem_sub = rem_sh - {1'b0, div_ff};
      over    = |acc_ff[127:61];
      mag_q   = over ? MD_LIM : {3'd0, acc_ff[60:0]};
      md_rsp.done   = (state_ff == U_DONE);
      md_rsp.result = zero_ff ? 64'sd0 : (neg_ff ? -mag_q : mag_q);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
         cnt_ff   <= 7'd0;
      end else begin
         case (state_ff)
            U_IDLE: begin
               if (md_req.start) begin
                  mag_a_ff <= mag_a_in;
                  mag_b_ff <= mag_b_in;
                  div_ff   <= mag_c_in;
                  neg_ff   <= md_req.a[63] ^ md_req.b[63] ^ md_req.c[63];
                  zero_ff  <= (md_req.c == 64'sd0);
                  pow2_ff  <= (md_req.c == Q_ONE);
                  acc_ff   <= 128'd0;
                  rem_ff   <= 64'd0;
                  cnt_ff   <= 7'd0;
                  state_ff <= (md_req.c == 64'sd0) ? U_DONE : U_MUL;
               end
            end
            U_MUL: begin
               if (cnt_ff[1:0] == 2'd3) begin
                  cnt_ff <= 7'd0;
                  if (pow2_ff) begin
                     acc_ff   <= acc_sum >> 30;
                     state_ff <= U_DONE;
                  end else begin
                     acc_ff   <= acc_sum;
                     state_ff <= U_DIV;
                  end
               end else begin
                  acc_ff <= acc_sum;
                  cnt_ff <= cnt_ff + 7'd1;
               end
            end
            U_DIV: begin
               rem_ff <= rem_ge ? rem_sub[63:0] : rem_sh[63:0];
               acc_ff <= {acc_ff[126:0], rem_ge};
               cnt_ff <= cnt_ff + 7'd1;
               if (cnt_ff == 7'd127) state_ff <= U_DONE;
            end
            U_DONE: begin
               state_ff <= U_IDLE;
            end
            default: state_ff <= U_IDLE;
         endcase
      end
   end

endmodule

>>> hdl/radial_table_interpolator.sv
// Radial table interpolator top level: tables, search and interpolation sequencer.
// Depends on rti_pkg, rti_muldiv and radial_table_interpolator_assert.svh.
//
// Load transactions (radius or sample writes) write one table entry. A query reads the two
// end radii, binary-searches the grid, fetches four neighbors, then runs fourteen
// multiply-divide steps through one shared unit: eight true divisions and six scalings
// by 2^-30. A query outside the grid skips the search and answers zero, not in range.
// The input is not ready while a query is in progress; a finished result waits in an
// output register while loads are taken.
`include "radial_table_interpolator_assert.svh"

module radial_table_interpolator import rti_pkg::*; #(
   parameter int GRID_DEPTH = 1024,
   parameter int NUM_STATES = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,  // state_index[2:0], grid_index[12:3], radius[44:13],
                                   // sample_value[76:45], zero pad
   input  logic [1:0]  req_tuser,  // opcode[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // value[31:0]
   output logic        rsp_tuser,  // in_range[0]
   input  logic        csr_we,
   input  logic [10:0] csr_wdata
);

   localparam int AW  = $clog2(GRID_DEPTH);
   localparam int SAW = $clog2(NUM_STATES * GRID_DEPTH);

   typedef enum logic [3:0] {
      S_IDLE, S_R0, S_RN, S_CHK, S_BS, S_BSW, S_FETCH, S_PREP, S_MDGO, S_MDW, S_OUT
   } state_type;

   typedef enum logic [3:0] {
      ST_A1, ST_A2, ST_P1, ST_B1, ST_B2, ST_P2, ST_Y1, ST_Y2,
      ST_W1, ST_U, ST_T1, ST_W2, ST_V, ST_T2
   } step_type;

   logic [1:0]  opcode;
   logic [2:0]  state_index;
   logic [9:0]  grid_index;
   logic [31:0] radius;
   logic [31:0] sample_value;

   assign opcode       = req_tuser;
   assign state_index  = req_tdata[2:0];
   assign grid_index   = req_tdata[12:3];
   assign radius       = req_tdata[44:13];
   assign sample_value = req_tdata[76:45];

   logic [31:0] radius_mem [GRID_DEPTH];
   logic [31:0] sample_mem [NUM_STATES * GRID_DEPTH];

   state_type state_ff;
   step_type  step_ff;
   logic [10:0] grid_count_ff;
   logic [AW:0] n_ff;
   logic [2:0]  st_ff;
   logic        st_ok_ff;
   logic [31:0] r_ff, r0_ff;
   logic [AW-1:0] lo_ff, hi_ff;
   logic [2:0]  fcnt_ff;
   logic [31:0] rr_ff [4];
   logic [31:0] fq_ff [4];
   logic [31:0] rad_q_ff, samp_q_ff;
   logic signed [63:0] h1_ff, h2_ff, h3_ff, f1_ff, f2_ff, f3_ff, f4_ff, x1_ff, x2_ff;
   logic signed [63:0] tmp0_ff, tmp1_ff, p1_ff, p2_ff, y1_ff, y2_ff, t1_ff;
   logic        rsp_tvalid_ff, rsp_inrange_ff;
   logic [31:0] rsp_value_ff;
   logic        res_inrange_ff;
   logic [31:0] res_value_ff;

   logic        req_accept;
   logic [AW-1:0] rad_raddr, mid;
   logic [SAW-1:0] samp_raddr, samp_waddr;
   logic [AW:0] n_in;
   int          gc_int;
   logic        m_first, m_last;
   logic signed [63:0] rr_s [4];
   logic signed [63:0] fq_s [4];
   logic signed [63:0] h1_in, h3_in, f1_in, f4_in, h2_in;
   logic signed [63:0] md_res, res_sum;
   md_req_type  md_req;
   md_rsp_type  md_rsp;

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_inrange_ff;

   always_comb begin
      gc_int = int'(grid_count_ff);
      if (gc_int < 3) n_in = (AW + 1)'(3);
      else if (gc_int > GRID_DEPTH) n_in = (AW + 1)'(GRID_DEPTH);
      else n_in = (AW + 1)'(gc_int);

      mid = AW'(({1'b0, lo_ff} + {1'b0, hi_ff}) >> 1);
      case (state_ff)
         S_RN:    rad_raddr = AW'(n_ff - (AW + 1)'(1));
         S_BS:    rad_raddr = mid;
         S_FETCH: rad_raddr = AW'({1'b0, hi_ff} - (AW + 1)'(2) + (AW + 1)'(fcnt_ff));
         default: rad_raddr = '0;
      endcase
      samp_raddr = SAW'(int'(st_ff) * GRID_DEPTH + int'(rad_raddr));
      samp_waddr = SAW'(int'(state_index) * GRID_DEPTH + int'(grid_index));

      for (int k = 0; k < 4; k++) begin
         rr_s[k] = {32'd0, rr_ff[k]};
         fq_s[k] = {{32{fq_ff[k][31]}}, fq_ff[k]};
      end
      m_first = (hi_ff == AW'(1));
      m_last  = ({1'b0, hi_ff} == n_ff - (AW + 1)'(1));
      h2_in   = rr_s[2] - rr_s[1];
      h1_in   = rr_s[1] - rr_s[0];
      h3_in   = rr_s[3] - rr_s[2];
      f1_in   = fq_s[0];
      f4_in   = fq_s[3];
      if (m_first) begin
         h1_in = -(h2_in + h3_in);
         f1_in = fq_s[3];
      end else if (m_last) begin
         h3_in = -(h1_in + h2_in);
         f4_in = fq_s[0];
      end

      md_req.start = (state_ff == S_MDGO);
      case (step_ff)
         ST_A1: begin md_req.a = f3_ff - f2_ff; md_req.b = h1_ff; md_req.c = h2_ff; end
         ST_A2: begin md_req.a = f2_ff - f1_ff; md_req.b = h2_ff; md_req.c = h1_ff; end
         ST_P1: begin
            md_req.a = tmp0_ff + tmp1_ff; md_req.b = h2_ff; md_req.c = h1_ff + h2_ff;
         end
         ST_B1: begin md_req.a = f4_ff - f3_ff; md_req.b = h2_ff; md_req.c = h3_ff; end
         ST_B2: begin md_req.a = f3_ff - f2_ff; md_req.b = h3_ff; md_req.c = h2_ff; end
         ST_P2: begin
            md_req.a = tmp0_ff + tmp1_ff; md_req.b = h2_ff; md_req.c = h2_ff + h3_ff;
         end
         ST_Y1: begin md_req.a = x1_ff; md_req.b = Q_ONE; md_req.c = h2_ff; end
         ST_Y2: begin md_req.a = x2_ff; md_req.b = Q_ONE; md_req.c = h2_ff; end
         ST_W1: begin md_req.a = 2 * f2_ff + p1_ff; md_req.b = y2_ff; md_req.c = Q_ONE; end
         ST_U: begin
            md_req.a = 3 * f2_ff + p1_ff + tmp0_ff; md_req.b = y2_ff; md_req.c = Q_ONE;
         end
         ST_T1: begin md_req.a = tmp1_ff; md_req.b = y2_ff; md_req.c = Q_ONE; end
         ST_W2: begin md_req.a = 2 * f3_ff - p2_ff; md_req.b = y1_ff; md_req.c = Q_ONE; end
         ST_V: begin
            md_req.a = 3 * f3_ff - p2_ff - tmp0_ff; md_req.b = y1_ff; md_req.c = Q_ONE;
         end
         ST_T2: begin md_req.a = tmp1_ff; md_req.b = y1_ff; md_req.c = Q_ONE; end
         default: begin md_req.a = '0; md_req.b = '0; md_req.c = '0; end
      endcase

      md_res  = md_rsp.result;
      res_sum = t1_ff + md_res;
   end

   rti_muldiv u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .md_req (md_req),
      .md_rsp (md_rsp)
   );

   always_ff @(posedge clock) begin
      if (req_accept && opcode == OP_RADIUS && int'(grid_index) < GRID_DEPTH)
         radius_mem[AW'(grid_index)] <= radius;
      rad_q_ff <= radius_mem[rad_raddr];
   end

   always_ff @(posedge clock) begin
      if (req_accept && opcode == OP_SAMPLE && int'(grid_index) < GRID_DEPTH
          && int'(state_index) < NUM_STATES)
         sample_mem[samp_waddr] <= sample_value;
      samp_q_ff <= sample_mem[samp_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         step_ff       <= ST_A1;
         grid_count_ff <= 11'd1024;
         rsp_tvalid_ff <= 1'b0;
         fcnt_ff       <= 3'd0;
      end else begin
         if (csr_we) grid_count_ff <= csr_wdata;
         // load the output register only once the previous transaction has left
         if (state_ff == S_OUT && (!rsp_tvalid_ff || rsp_tready)) begin
            rsp_tvalid_ff  <= 1'b1;
            rsp_value_ff   <= res_value_ff;
            rsp_inrange_ff <= res_inrange_ff;
         end else if (rsp_tvalid_ff && rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_accept && opcode == OP_QUERY) begin
                  st_ff    <= state_index;
                  st_ok_ff <= int'(state_index) < NUM_STATES;
                  r_ff     <= radius;
                  n_ff     <= n_in;
                  state_ff <= S_R0;
               end
            end
            S_R0: state_ff <= S_RN;
            S_RN: begin
               r0_ff    <= rad_q_ff;
               state_ff <= S_CHK;
            end
            S_CHK: begin
               if (st_ok_ff && r_ff >= r0_ff && r_ff <= rad_q_ff) begin
                  lo_ff    <= '0;
                  hi_ff    <= AW'(n_ff - (AW + 1)'(1));
                  state_ff <= S_BS;
               end else begin
                  res_value_ff   <= 32'd0;
                  res_inrange_ff <= 1'b0;
                  state_ff       <= S_OUT;
               end
            end
            S_BS: begin
               if (hi_ff - lo_ff == AW'(1)) begin
                  fcnt_ff  <= 3'd0;
                  state_ff <= S_FETCH;
               end else begin
                  state_ff <= S_BSW;
               end
            end
            S_BSW: begin
               if (rad_q_ff < r_ff) lo_ff <= mid;
               else hi_ff <= mid;
               state_ff <= S_BS;
            end
            S_FETCH: begin
               if (fcnt_ff != 3'd0) begin
                  rr_ff[2'(fcnt_ff - 3'd1)] <= rad_q_ff;
                  fq_ff[2'(fcnt_ff - 3'd1)] <= samp_q_ff;
               end
               fcnt_ff <= fcnt_ff + 3'd1;
               if (fcnt_ff == 3'd4) state_ff <= S_PREP;
            end
            S_PREP: begin
               h1_ff    <= h1_in;
               h2_ff    <= h2_in;
               h3_ff    <= h3_in;
               f1_ff    <= f1_in;
               f2_ff    <= fq_s[1];
               f3_ff    <= fq_s[2];
               f4_ff    <= f4_in;
               x1_ff    <= {32'd0, r_ff} - rr_s[1];
               x2_ff    <= {32'd0, r_ff} - rr_s[2];
               step_ff  <= ST_A1;
               state_ff <= S_MDGO;
            end
            S_MDGO: state_ff <= S_MDW;
            S_MDW: begin
               if (md_rsp.done) begin
                  case (step_ff)
                     ST_A1, ST_B1, ST_W1, ST_W2: tmp0_ff <= md_res;
                     ST_A2, ST_B2, ST_U, ST_V:   tmp1_ff <= md_res;
                     ST_P1: p1_ff <= (md_res > SLOPE_LIM) ? SLOPE_LIM :
                                     (md_res < -SLOPE_LIM) ? -SLOPE_LIM : md_res;
                     ST_P2: p2_ff <= (md_res > SLOPE_LIM) ? SLOPE_LIM :
                                     (md_res < -SLOPE_LIM) ? -SLOPE_LIM : md_res;
                     ST_Y1: y1_ff <= (md_res > Q_ONE) ? Q_ONE :
                                     (md_res < -Q_ONE) ? -Q_ONE : md_res;
                     ST_Y2: y2_ff <= (md_res > Q_ONE) ? Q_ONE :
                                     (md_res < -Q_ONE) ? -Q_ONE : md_res;
                     ST_T1: t1_ff <= md_res;
                     default: ;
                  endcase
                  if (step_ff == ST_T2) begin
                     if (res_sum > 64'sd2147483647) res_value_ff <= 32'h7FFF_FFFF;
                     else if (res_sum < -64'sd2147483648) res_value_ff <= 32'h8000_0000;
                     else res_value_ff <= res_sum[31:0];
                     res_inrange_ff <= 1'b1;
                     state_ff       <= S_OUT;
                  end else begin
                     step_ff  <= step_type'(step_ff + 4'd1);
                     state_ff <= S_MDGO;
                  end
               end
            end
            S_OUT: begin
               if (!rsp_tvalid_ff || rsp_tready) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `RTI_ASSERT_NEXT(a_query_blocks, req_accept && opcode == OP_QUERY, !req_tready)
   `RTI_ASSERT_NOW(a_out_of_range_zero, rsp_tvalid && !rsp_tuser, rsp_tdata == 32'd0)
   `RTI_ASSERT_NOW(a_search_order, state_ff == S_BSW, lo_ff < hi_ff)

endmodule

>>> tb/interp_checker.sv
// Scoreboard for the radial table interpolator: mirrors the grid and sample tables,
// predicts each query result and compares it with the result channel. Needs rti_pkg.
`timescale 1ns / 1ps

module interp_checker import rti_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [79:0] req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,
   input  logic        rsp_tuser,
   input  logic        csr_we,
   input  logic [10:0] csr_wdata,
   output int          fail_count,
   output int          pending
);

   localparam int DEPTH = 1024;
   localparam int STATES = 8;

   typedef struct packed {
      logic [31:0] value;
      logic        in_range;
   } interp_result_type;

   logic [31:0]       grid_radius [DEPTH];
   logic [31:0]       samples [STATES][DEPTH];
   logic [10:0]       grid_count_q;
   interp_result_type pending_results [$];

   function automatic longint scaled_muldiv(longint a, longint b, longint c);
      logic [63:0]  ma, mb, mc;
      logic [127:0] q;
      logic         neg;
      if (c == 0) return 0;
      neg = (a < 0) ^ (b < 0) ^ (c < 0);
      ma = a[63] ? ~a + 64'd1 : a;
      mb = b[63] ? ~b + 64'd1 : b;
      mc = c[63] ? ~c + 64'd1 : c;
      q = ({64'd0, ma} * {64'd0, mb}) / {64'd0, mc};
      if (q >= (128'd1 << 61)) q = 128'(MD_LIM);
      return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
   endfunction

   function automatic longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic longint rad(int i);
      return longint'({32'd0, grid_radius[i]});
   endfunction

   function automatic longint smp(int st, int i);
      return longint'(signed'(samples[st][i]));
   endfunction

   function automatic longint hermite_value(int st, int n, longint r);
      int     lo, hi, mid, m;
      longint h1, h2, h3, f1, f2, f3, f4, p1, p2, y1, y2, u, v, t1, t2;
      lo = 0;
      hi = n - 1;
      while (hi - lo != 1) begin
         mid = (lo + hi) / 2;
         if (rad(mid) < r) lo = mid;
         else hi = mid;
      end
      m = hi;
      h2 = rad(m) - rad(m - 1);
      f2 = smp(st, m - 1);
      f3 = smp(st, m);
      if (m == 1) begin
         h3 = rad(m + 1) - rad(m);
         f4 = smp(st, m + 1);
         h1 = -(h2 + h3);
         f1 = f4;
      end else if (m == n - 1) begin
         h1 = rad(m - 1) - rad(m - 2);
         f1 = smp(st, m - 2);
         h3 = -(h1 + h2);
         f4 = f1;
      end else begin
         h1 = rad(m - 1) - rad(m - 2);
         h3 = rad(m + 1) - rad(m);
         f1 = smp(st, m - 2);
         f4 = smp(st, m + 1);
      end
      p1 = scaled_muldiv(scaled_muldiv(f3 - f2, h1, h2) + scaled_muldiv(f2 - f1, h2, h1),
                         h2, h1 + h2);
      p2 = scaled_muldiv(scaled_muldiv(f4 - f3, h2, h3) + scaled_muldiv(f3 - f2, h3, h2),
                         h2, h2 + h3);
      p1 = clip(p1, -SLOPE_LIM, SLOPE_LIM);
      p2 = clip(p2, -SLOPE_LIM, SLOPE_LIM);
      y1 = clip(scaled_muldiv(r - rad(m - 1), Q_ONE, h2), -Q_ONE, Q_ONE);
      y2 = clip(scaled_muldiv(r - rad(m), Q_ONE, h2), -Q_ONE, Q_ONE);
      u = 3 * f2 + p1 + scaled_muldiv(2 * f2 + p1, y2, Q_ONE);
      t1 = scaled_muldiv(scaled_muldiv(u, y2, Q_ONE), y2, Q_ONE);
      v = 3 * f3 - p2 - scaled_muldiv(2 * f3 - p2, y1, Q_ONE);
      t2 = scaled_muldiv(scaled_muldiv(v, y1, Q_ONE), y1, Q_ONE);
      return clip(t1 + t2, -64'sd2147483648, 64'sd2147483647);
   endfunction

   function automatic interp_result_type predict_query(int st, longint r);
      interp_result_type res;
      int                n;
      n = grid_count_q;
      if (n < 3) n = 3;
      if (n > DEPTH) n = DEPTH;
      res = '0;
      if (st < STATES && r >= rad(0) && r <= rad(n - 1)) begin
         res.in_range = 1'b1;
         res.value = 32'(hermite_value(st, n, r));
      end
      return res;
   endfunction

   always @(posedge clock) begin
      interp_result_type want;
      logic [2:0]        st;
      logic [9:0]        gi;
      logic [31:0]       r, sv;
      if (reset) begin
         grid_count_q = 11'd1024;
         fail_count <= 0;
         pending <= 0;
         pending_results.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_results.size() == 0) begin
               $display("%0t: unexpected result value=%h in_range=%b", $time, rsp_tdata,
                        rsp_tuser);
               fail_count <= fail_count + 1;
            end else begin
               want = pending_results.pop_front();
               if (want.value !== rsp_tdata || want.in_range !== rsp_tuser) begin
                  $display("%0t: mismatch expected value=%h in_range=%b, got value=%h in_range=%b",
                           $time, want.value, want.in_range, rsp_tdata, rsp_tuser);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (csr_we) grid_count_q = csr_wdata;
         if (req_tvalid && req_tready) begin
            st = req_tdata[2:0];
            gi = req_tdata[12:3];
            r  = req_tdata[44:13];
            sv = req_tdata[76:45];
            case (req_tuser)
               OP_RADIUS: grid_radius[gi] = r;
               OP_SAMPLE: samples[st][gi] = sv;
               OP_QUERY:  pending_results.push_back(predict_query(st, longint'({32'd0, r})));
               default: ;
            endcase
         end
         pending <= pending_results.size();
      end
   end

endmodule

>>> tb/tb.sv
// Top of the radial table interpolator testbench: clock, reset, stimulus and verdict.
// Depends on rti_pkg, radial_table_interpolator and interp_checker.
`timescale 1ns / 1ps

module tb;
   import rti_pkg::*;

   localparam int DEPTH = 1024;
   localparam int CYCLE_LIMIT = 4000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [79:0] req_tdata = '0;
   logic [1:0]  req_tuser = OP_RADIUS;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_we = 1'b0;
   logic [10:0] csr_wdata = '0;
   int          fail_count, pending;

   logic [31:0] grid_shadow [DEPTH];
   bit          grid_written [DEPTH];
   bit          sample_written [8][DEPTH];
   bit          no_idle;
   int          items, cycles, rsp_wait, grid_used;

   always #5 clock = ~clock;

   radial_table_interpolator u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   interp_checker u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_we(csr_we), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending(pending)
   );

   function automatic int draw_gap();
      return no_idle ? 0 : $urandom_range(0, 3);
   endfunction

   always @(posedge clock) begin
      int w;
      cycles <= cycles + 1;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_wait <= 1;
      end else if (rsp_tvalid && rsp_tready) begin
         w = draw_gap();
         rsp_wait <= w;
         rsp_tready <= (w == 0);
      end else if (rsp_wait > 0) begin
         rsp_wait <= rsp_wait - 1;
         rsp_tready <= (rsp_wait == 1);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (cycles > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   task automatic send(logic [1:0] op, logic [2:0] st, logic [9:0] gi, logic [31:0] r,
                       logic [31:0] sv);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {3'b000, sv, r, gi, st};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items++;
      if (op == OP_RADIUS) begin
         grid_shadow[gi] = r;
         grid_written[gi] = 1'b1;
      end else if (op == OP_SAMPLE) begin
         sample_written[st][gi] = 1'b1;
      end
   endtask

   // quiesce, then write grid_count
   task automatic set_grid(logic [10:0] v);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      grid_used = v < 3 ? 3 : (v > DEPTH ? DEPTH : v);
   endtask

   function automatic logic [31:0] random_sample();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2, 3: return 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
         default: return $urandom();
      endcase
   endfunction

   function automatic bit state_ready(int st);
      for (int i = 0; i < grid_used; i++)
         if (!sample_written[st][i]) return 1'b0;
      return 1'b1;
   endfunction

   function automatic logic [31:0] query_radius();
      logic [31:0] lo, hi;
      lo = grid_shadow[0];
      hi = grid_shadow[grid_used - 1];
      case ($urandom_range(0, 9))
         0: return grid_shadow[$urandom_range(0, grid_used - 1)];
         1: return lo == 0 ? lo : $urandom_range(0, lo - 1);
         2: return hi == 32'hffff_ffff ? hi : $urandom_range(hi + 1, 32'hffff_ffff);
         3: return $urandom();
         default: return hi >= lo ? $urandom_range(lo, hi) : $urandom();
      endcase
   endfunction

   task automatic load_grid(int mode, int n, int max_step);
      logic [31:0] r;
      r = $urandom_range(0, 1 << 24);
      for (int i = 0; i < n; i++) begin
         if (mode == 5) r = $urandom();
         else if (i > 0) r = r + (mode == 4 ? $urandom_range(0, 2) * max_step / 2
                                            : $urandom_range(1, max_step));
         send(OP_RADIUS, 3'($urandom()), 10'(i), r, $urandom());
      end
   endtask

   task automatic run_queries(int count);
      int          st, tries;
      logic [2:0]  any_st;
      for (int q = 0; q < count; q++) begin
         case ($urandom_range(0, 7))
            0: if (grid_written[0])
                  send(OP_RADIUS, 3'($urandom()), 10'($urandom_range(grid_used, DEPTH - 1)),
                       $urandom(), $urandom());
            1: begin
               any_st = 3'($urandom());
               send(OP_SAMPLE, any_st, 10'($urandom_range(0, DEPTH - 1)), $urandom(),
                    random_sample());
            end
            2: send(2'd3, 3'($urandom()), 10'($urandom()), $urandom(), $urandom());
            default: ;
         endcase
         tries = 0;
         do begin
            st = $urandom_range(0, 7);
            tries++;
         end while (!state_ready(st) && tries < 64);
         if (state_ready(st))
            send(OP_QUERY, 3'(st), 10'($urandom()), query_radius(), $urandom());
      end
   endtask

   initial begin
      int n, k, mode;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extreme radii and samples on a three-point grid
      set_grid(11'd0);
      send(OP_RADIUS, 3'd0, 10'd0, 32'h0000_0000, 32'h0);
      send(OP_RADIUS, 3'd7, 10'd1, 32'h8000_0000, 32'hffff_ffff);
      send(OP_RADIUS, 3'd0, 10'd2, 32'hffff_ffff, 32'h0);
      send(OP_SAMPLE, 3'd7, 10'd0, 32'h0, 32'h8000_0000);
      send(OP_SAMPLE, 3'd7, 10'd1, 32'hffff_ffff, 32'h7fff_ffff);
      send(OP_SAMPLE, 3'd7, 10'd2, 32'h0, 32'h0000_0000);
      send(OP_SAMPLE, 3'd0, 10'd1023, 32'h0, 32'h7fff_ffff);
      send(2'd3, 3'd7, 10'd1023, 32'hffff_ffff, 32'hffff_ffff);
      send(OP_QUERY, 3'd7, 10'd0, 32'h0000_0000, 32'h0);
      send(OP_QUERY, 3'd7, 10'd1023, 32'h4000_0000, 32'hffff_ffff);
      send(OP_QUERY, 3'd7, 10'd0, 32'h8000_0000, 32'h0);
      send(OP_QUERY, 3'd7, 10'd0, 32'hc000_0001, 32'h0);
      send(OP_QUERY, 3'd7, 10'd0, 32'hffff_ffff, 32'h0);
      send(OP_RADIUS, 3'd0, 10'd0, 32'h0000_0100, 32'h0);
      send(OP_QUERY, 3'd7, 10'd0, 32'h0000_00ff, 32'h0);
      send(OP_RADIUS, 3'd0, 10'd1, 32'h0000_0100, 32'h0);
      send(OP_QUERY, 3'd7, 10'd0, 32'h0000_0100, 32'h0);
      send(OP_QUERY, 3'd7, 10'd0, 32'h7000_0000, 32'h0);

      while (items < 850) begin
         no_idle = ($urandom_range(0, 4) == 0);
         n = $urandom_range(0, 3) == 0 ? $urandom_range(3, 5) : $urandom_range(3, 24);
         set_grid(n == 3 && $urandom_range(0, 1) ? 11'($urandom_range(0, 2)) : 11'(n));
         mode = $urandom_range(0, 5);
         load_grid(mode, n, $urandom_range(0, 1) ? 1 << 26 : $urandom_range(1, 4096));
         k = $urandom_range(1, 3);
         for (int s = 0; s < k; s++) begin
            int st;
            st = $urandom_range(0, 7);
            for (int i = 0; i < n; i++)
               send(OP_SAMPLE, 3'(st), 10'(i), $urandom(), random_sample());
         end
         run_queries($urandom_range(8, 18));
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (fail_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

>>> files.f
+incdir+hdl
hdl/rti_pkg.sv
hdl/rti_muldiv.sv
hdl/radial_table_interpolator.sv
tb/interp_checker.sv
tb/tb.sv
